[rtl/lpht_pkg.sv]
// Shared types, sizes and codes of the linear-probing hash table.
package lpht_pkg;

  localparam int CAPACITY = 256;
  localparam int SLOT_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 32;
  localparam int VAL_W    = 32;
  localparam int FILL_W   = 8;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;
  localparam logic [FILL_W-1:0] MAX_FILL_RESET = 8'd179;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_ERASE  = 2'd2,
    OP_CLEAR  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DUP      = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    REG_MAX_FILL = 1'b0
  } reg_index_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SRD,
    S_SCMP,
    S_GRD,
    S_GCMP,
    S_GPROBE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [KEY_W-1:0] lookup_key;
    logic [VAL_W-1:0] new_value;
  } in_req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [VAL_W-1:0]  found_value;
    logic [SLOT_W-1:0] slot_index;
    logic [CNT_W-1:0]  entry_count;
  } out_rsp_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } slot_entry_t;

  // Controller to datapath.
  typedef struct packed {
    logic    load;
    logic    do_clear;
    logic    rd_ptr;
    logic    step_ptr;
    logic    do_insert;
    logic    do_erase;
    logic    rd_gap;
    logic    take_gap;
    logic    step_probe;
    logic    place_probe;
    logic    res_we;
    status_t res_code;
    logic    res_slot_we;
    logic    res_val_we;
    logic    out_load;
  } lpht_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    opcode_t opcode;
    logic    occ_ptr;
    logic    ptr_wrap;
    logic    key_match;
    logic    fill_ok;
    logic    occ_gap;
    logic    gap_wrap;
    logic    occ_probe;
    logic    out_free;
  } lpht_status_t;

endpackage

[rtl/lpht_ctrl.sv]
// Operation sequencer of the hash table: probe, erase gap closing and result hand-off.
module lpht_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  lpht_pkg::lpht_status_t st,
  output lpht_pkg::lpht_cmd_t  cmd
);
  import lpht_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_SRD;
        end
      end
      S_SRD: begin
        if (st.opcode == OP_CLEAR || st.ptr_wrap || !st.occ_ptr) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SCMP;
        end
      end
      S_SCMP: begin
        if (!st.key_match) begin
          state_nxt = S_SRD;
        end else if (st.opcode == OP_ERASE) begin
          state_nxt = S_GRD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_GRD: begin
        if (st.gap_wrap || !st.occ_gap) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_GCMP;
        end
      end
      S_GCMP: state_nxt = S_GPROBE;
      S_GPROBE: begin
        if (!st.occ_probe) begin
          state_nxt = S_GRD;
        end
      end
      S_DONE: begin
        if (st.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.res_code = ST_OK;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_SRD: begin
        if (st.opcode == OP_CLEAR) begin
          cmd.do_clear = 1'b1;
        end else if (st.ptr_wrap || !st.occ_ptr) begin
          cmd.res_we = 1'b1;
          if (st.opcode == OP_INSERT) begin
            if (st.ptr_wrap || !st.fill_ok) begin
              cmd.res_code = ST_FULL;
            end else begin
              cmd.res_code    = ST_OK;
              cmd.res_slot_we = 1'b1;
              cmd.do_insert   = 1'b1;
            end
          end else begin
            cmd.res_code = ST_NOTFOUND;
          end
        end else begin
          cmd.rd_ptr = 1'b1;
        end
      end
      S_SCMP: begin
        if (!st.key_match) begin
          cmd.step_ptr = 1'b1;
        end else begin
          cmd.res_we      = 1'b1;
          cmd.res_slot_we = 1'b1;
          case (st.opcode)
            OP_INSERT: cmd.res_code = ST_DUP;
            OP_LOOKUP: begin
              cmd.res_code   = ST_OK;
              cmd.res_val_we = 1'b1;
            end
            OP_ERASE: begin
              cmd.res_code = ST_OK;
              cmd.do_erase = 1'b1;
            end
            default: cmd.res_code = ST_OK;
          endcase
        end
      end
      S_GRD: begin
        cmd.rd_gap = !(st.gap_wrap || !st.occ_gap);
      end
      S_GCMP: cmd.take_gap = 1'b1;
      S_GPROBE: begin
        if (st.occ_probe) begin
          cmd.step_probe = 1'b1;
        end else begin
          cmd.place_probe = 1'b1;
        end
      end
      S_DONE: cmd.out_load = st.out_free;
      default: ;
    endcase
  end

endmodule

[rtl/lpht_dpath.sv]
// Slot storage, occupancy bits, probe pointers, config register and result register.
module lpht_dpath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lpht_pkg::in_req_t           in_req,
  output lpht_pkg::out_rsp_t          out_rsp,
  output logic                        out_valid,
  input  logic                        out_ready,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lpht_pkg::ADDR_W-1:0] paddr,
  input  logic [lpht_pkg::DATA_W-1:0] pwdata,
  output logic [lpht_pkg::DATA_W-1:0] prdata,
  input  lpht_pkg::lpht_cmd_t         cmd,
  output lpht_pkg::lpht_status_t      st
);
  import lpht_pkg::*;

  slot_entry_t         mem [CAPACITY];
  slot_entry_t         rdata_r;
  slot_entry_t         wdata;
  logic [SLOT_W-1:0]   raddr, waddr;
  logic                mem_we;

  in_req_t             req_r;
  logic [SLOT_W-1:0]   ptr_r, gap_r, probe_r;
  logic [CNT_W-1:0]    n_r, m_r, count_r;
  logic [CAPACITY-1:0] occ_r;
  slot_entry_t         mv_r;
  logic [FILL_W-1:0]   max_fill_r;
  logic [1:0]          res_status_r;
  logic [VAL_W-1:0]    res_value_r;
  logic [SLOT_W-1:0]   res_slot_r;
  logic                out_valid_r;
  out_rsp_t            out_rsp_r;
  logic                reg_sel;

  assign raddr  = cmd.rd_gap ? gap_r : ptr_r;
  assign mem_we = cmd.do_insert || cmd.place_probe;
  assign waddr  = cmd.place_probe ? probe_r : ptr_r;
  assign wdata  = cmd.place_probe ? mv_r : slot_entry_t'{req_r.lookup_key, req_r.new_value};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r   <= '0;
      count_r <= '0;
    end else if (cmd.do_clear) begin
      occ_r   <= '0;
      count_r <= '0;
    end else begin
      if (cmd.do_insert) begin
        occ_r[ptr_r] <= 1'b1;
        count_r      <= count_r + CNT_W'(1);
      end
      if (cmd.do_erase) begin
        occ_r[ptr_r] <= 1'b0;
        count_r      <= count_r - CNT_W'(1);
      end
      if (cmd.take_gap) begin
        occ_r[gap_r] <= 1'b0;
      end
      if (cmd.place_probe) begin
        occ_r[probe_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_req;
      ptr_r <= in_req.lookup_key[SLOT_W-1:0];
      n_r   <= '0;
    end else if (cmd.step_ptr) begin
      ptr_r <= ptr_r + SLOT_W'(1);
      n_r   <= n_r + CNT_W'(1);
    end
    if (cmd.do_erase) begin
      gap_r <= ptr_r + SLOT_W'(1);
      m_r   <= '0;
    end else if (cmd.place_probe) begin
      gap_r <= gap_r + SLOT_W'(1);
      m_r   <= m_r + CNT_W'(1);
    end
    if (cmd.take_gap) begin
      mv_r    <= rdata_r;
      probe_r <= rdata_r.key[SLOT_W-1:0];
    end else if (cmd.step_probe) begin
      probe_r <= probe_r + SLOT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load || cmd.do_clear) begin
      res_status_r <= ST_OK;
      res_value_r  <= '0;
      res_slot_r   <= '0;
    end else begin
      if (cmd.res_we) begin
        res_status_r <= cmd.res_code;
      end
      if (cmd.res_slot_we) begin
        res_slot_r <= ptr_r;
      end
      if (cmd.res_val_we) begin
        res_value_r <= rdata_r.value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_rsp_r <= out_rsp_t'{res_status_r, res_value_r, res_slot_r, count_r};
    end
  end

  assign reg_sel = (paddr[ADDR_W-1] == REG_MAX_FILL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_fill_r <= MAX_FILL_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      max_fill_r <= pwdata[FILL_W-1:0];
    end
  end

  assign prdata    = reg_sel ? DATA_W'(max_fill_r) : '0;
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  assign st.opcode    = opcode_t'(req_r.opcode);
  assign st.occ_ptr   = occ_r[ptr_r];
  assign st.ptr_wrap  = (n_r == CNT_W'(CAPACITY));
  assign st.key_match = (rdata_r.key == req_r.lookup_key);
  assign st.fill_ok   = (count_r < CNT_W'(max_fill_r));
  assign st.occ_gap   = occ_r[gap_r];
  assign st.gap_wrap  = (m_r == CNT_W'(CAPACITY));
  assign st.occ_probe = occ_r[probe_r];
  assign st.out_free  = !out_valid_r || out_ready;

endmodule

[rtl/linear_probe_hash_table.sv]
// Top level of the linear-probing key/value hash table.
//
// The table has 256 slots for key/value pairs of 32 bits each; a key's home slot is
// its low 8 bits, and probing walks forward one slot at a time with wrap-around.
// Each request is insert, lookup, erase or clear, and yields exactly one response.
// Requests are handled one at a time: a new request is taken only once the
// previous one has finished its work, though its response may still wait in the
// output register. The slot memory has a registered read, so each probed slot is
// first read and then compared. A lookup, insert or erase probes at most 256 slots.
// An erase then reads, for every entry in the cluster that follows the freed slot,
// that entry and probes forward from its home slot to place it again. Clear needs
// no probing, as the occupancy bits sit in flip-flops and clear at once. No
// clearing pass is needed after reset. The max_fill register at byte address 0
// caps how many entries an insert may create, at most 255 as it is 8 bits wide;
// it resets to 179.
module linear_probe_hash_table (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  lpht_pkg::in_req_t           in_req,
  output logic                        out_valid,
  input  logic                        out_ready,
  output lpht_pkg::out_rsp_t          out_rsp,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lpht_pkg::ADDR_W-1:0] paddr,
  input  logic [lpht_pkg::DATA_W-1:0] pwdata,
  output logic [lpht_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import lpht_pkg::*;

  lpht_cmd_t    cmd;
  lpht_status_t st;

  // The port never inserts wait states.
  assign pready = 1'b1;

  lpht_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  lpht_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .out_rsp   (out_rsp),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .cmd       (cmd),
    .st        (st)
  );

endmodule

[rtl/lpht_checker.sv]
// Port-level checks of the hash table and the bind that attaches them.
module lpht_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input lpht_pkg::out_rsp_t   out_rsp,
  input logic                 pready
);
  import lpht_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_rsp))
    else $error("response changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while one is in progress");

  a_miss_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_rsp.status == ST_NOTFOUND || out_rsp.status == ST_FULL)
      |-> out_rsp.found_value == '0 && out_rsp.slot_index == '0)
    else $error("miss response carries value or slot");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_rsp.entry_count <= CNT_W'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready low");

endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_rsp   (out_rsp),
  .pready    (pready)
);
